[rtl/pcc_pkg.sv]
// Shared types and constants for the Pearson correlation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcc_pkg;

  // Result status codes.
  localparam int STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_VAR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  // Q2.14 coefficient: the magnitude search finds 15 bits, 1.0 is bit 14.
  localparam int COEF_W     = 16;
  localparam int ROOT_BITS  = 15;
  localparam int ROOT_IDX_W = 4;
  localparam int ROOT_SHIFT = 2 * (ROOT_BITS - 1);
  localparam int COEF_ONE   = 1 << (ROOT_BITS - 1);

  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic go;
    logic accumulate;
    logic subtract;
  } mac_ctl_t;

endpackage

`default_nettype wire

[rtl/pcc_accum.sv]
// Running sums for the Pearson correlation block: count, sum x, sum y,
// sum xy, sum xx, sum yy. One small multiplier is reused over four phases.
// Depends on pcc_pkg.
`default_nettype none

module pcc_accum
  import pcc_pkg::*;
#(
  parameter int MAX_PAIRS   = 256,
  parameter int SAMPLE_BITS = 12,
  parameter int CNT_W       = $clog2(MAX_PAIRS + 1),
  parameter int SX_W        = SAMPLE_BITS + CNT_W,
  parameter int SQ_W        = 2 * SAMPLE_BITS + CNT_W
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  acc_ctl_t                      ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic signed [SAMPLE_BITS-1:0] y,
  output logic                          done,
  output logic                          ovf,
  output logic [CNT_W-1:0]              cnt,
  output logic signed [SX_W-1:0]        sum_x,
  output logic signed [SX_W-1:0]        sum_y,
  output logic signed [SQ_W-1:0]        sum_xy,
  output logic signed [SQ_W-1:0]        sum_xx,
  output logic signed [SQ_W-1:0]        sum_yy
);

  localparam int PW = 2 * SAMPLE_BITS;

  logic                          active_r;
  logic [1:0]                    phase_r;
  logic                          done_r;
  logic                          ovf_r;
  logic [CNT_W-1:0]              cnt_r;
  logic signed [SX_W-1:0]        sum_x_r, sum_y_r;
  logic signed [SQ_W-1:0]        sum_xy_r, sum_xx_r, sum_yy_r;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic signed [SAMPLE_BITS-1:0] mul_a, mul_b;
  logic signed [PW-1:0]          prod_r;
  logic signed [SQ_W-1:0]        prod_ext;
  logic                          has_room;

  // Phase 0 forms x*y, phase 1 x*x, phase 2 y*y; each is summed a phase later.
  assign mul_a    = (phase_r == 2'd2) ? y_r : x_r;
  assign mul_b    = (phase_r == 2'd1) ? x_r : y_r;
  assign prod_ext = {{(SQ_W - PW){prod_r[PW-1]}}, prod_r};
  assign has_room = (cnt_r < CNT_W'(MAX_PAIRS));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r <= x;
      y_r <= y;
    end
    if (active_r) begin
      prod_r <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= 2'd0;
      done_r   <= 1'b0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xy_r <= '0;
      sum_xx_r <= '0;
      sum_yy_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        ovf_r    <= 1'b0;
        cnt_r    <= '0;
        sum_x_r  <= '0;
        sum_y_r  <= '0;
        sum_xy_r <= '0;
        sum_xx_r <= '0;
        sum_yy_r <= '0;
      end else if (ctl.start) begin
        if (has_room) begin
          active_r <= 1'b1;
          phase_r  <= 2'd0;
        end else begin
          // A pair beyond capacity is dropped and remembered.
          ovf_r  <= 1'b1;
          done_r <= 1'b1;
        end
      end else if (active_r) begin
        phase_r <= phase_r + 2'd1;
        case (phase_r)
          2'd0: begin
            cnt_r   <= cnt_r + CNT_W'(1);
            sum_x_r <= sum_x_r + {{(SX_W - SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
            sum_y_r <= sum_y_r + {{(SX_W - SAMPLE_BITS){y_r[SAMPLE_BITS-1]}}, y_r};
          end
          2'd1: sum_xy_r <= sum_xy_r + prod_ext;
          2'd2: sum_xx_r <= sum_xx_r + prod_ext;
          default: begin
            sum_yy_r <= sum_yy_r + prod_ext;
            active_r <= 1'b0;
            done_r   <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done   = done_r;
  assign ovf    = ovf_r;
  assign cnt    = cnt_r;
  assign sum_x  = sum_x_r;
  assign sum_y  = sum_y_r;
  assign sum_xy = sum_xy_r;
  assign sum_xx = sum_xx_r;
  assign sum_yy = sum_yy_r;

endmodule

`default_nettype wire

[rtl/pcc_mac.sv]
// Shared shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Computes acc = (accumulate ? acc : 0) +/- a * b for a signed b of nbits bits.
// Depends on pcc_pkg.
`default_nettype none

module pcc_mac
  import pcc_pkg::*;
#(
  parameter int A_W = 84,
  parameter int B_W = 42,
  parameter int N_W = $clog2(B_W + 1)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mac_ctl_t             ctl,
  input  wire logic [A_W-1:0]  a,
  input  wire logic [B_W-1:0]  b,
  input  wire logic [N_W-1:0]  nbits,
  output logic                 done,
  output logic [A_W-1:0]       result
);

  logic [A_W-1:0] a_sh_r;
  logic [B_W-1:0] b_sh_r;
  logic [N_W-1:0] cnt_r;
  logic [A_W-1:0] acc_r;
  logic           sub_r;
  logic           done_r;
  logic           neg;
  logic [A_W-1:0] term;

  // The top bit of a two's complement multiplier carries negative weight.
  assign neg  = sub_r ^ (cnt_r == N_W'(1));
  assign term = b_sh_r[0] ? a_sh_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      a_sh_r <= a;
      b_sh_r <= b;
      sub_r  <= ctl.subtract;
      if (!ctl.accumulate) begin
        acc_r <= '0;
      end
    end else if (cnt_r != '0) begin
      acc_r  <= acc_r + (term ^ {A_W{neg}}) + {{(A_W - 1){1'b0}}, neg};
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        cnt_r <= nbits;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - N_W'(1);
        if (cnt_r == N_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

[rtl/pcc_root.sv]
// Bit-serial search for the largest q with q*q*d <= 2^28 * t, which is the
// coefficient magnitude, found one result bit at a time. Depends on pcc_pkg.
`default_nettype none

module pcc_root
  import pcc_pkg::*;
#(
  parameter int T_W = 84
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  go,
  input  wire logic [T_W-1:0]  t,
  input  wire logic [T_W-1:0]  d,
  output logic                 done,
  output logic [ROOT_BITS-1:0] q
);

  localparam int R_W = T_W + 2 * ROOT_BITS + 2;
  localparam int PAD = R_W - T_W - ROOT_SHIFT;

  // e_r holds the remaining slack, psh_r = q*d << (bit+1), dsh_r = d << 2*bit.
  logic [R_W-1:0]        e_r, psh_r, dsh_r, delta_r;
  logic [R_W:0]          diff;
  logic [ROOT_BITS-1:0]  q_r;
  logic [ROOT_IDX_W-1:0] bit_r;
  logic                  phase_r;
  logic                  run_r;
  logic                  done_r;

  assign diff = {1'b0, e_r} - {1'b0, delta_r};

  always_ff @(posedge clk) begin
    if (go) begin
      e_r   <= {{PAD{1'b0}}, t, {ROOT_SHIFT{1'b0}}};
      dsh_r <= {{PAD{1'b0}}, d, {ROOT_SHIFT{1'b0}}};
      psh_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      if (!phase_r) begin
        delta_r <= psh_r + dsh_r;
      end else begin
        if (!diff[R_W]) begin
          e_r        <= diff[R_W-1:0];
          psh_r      <= (delta_r + dsh_r) >> 1;
          q_r[bit_r] <= 1'b1;
        end else begin
          psh_r <= psh_r >> 1;
        end
        dsh_r <= dsh_r >> 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 1'b0;
      bit_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r   <= 1'b1;
        phase_r <= 1'b0;
        bit_r   <= ROOT_IDX_W'(ROOT_BITS - 1);
      end else if (run_r) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          if (bit_r == '0) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            bit_r <= bit_r - ROOT_IDX_W'(1);
          end
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

[rtl/pearson_correlation.sv]
// Pearson correlation of paired samples: top level with sequencer and output register.
// Depends on pcc_pkg, pcc_accum, pcc_mac and pcc_root.
//
// Usage: each input item is one pair (in_sample_x, in_sample_y) with in_last_pair
// marking the end of a set. Items are taken on the in_ channel (in_valid, in_stall);
// one result item per set leaves on the out_ channel (out_valid, out_stall) holding
// the coefficient in Q2.14 (16384 is 1.0, truncated toward zero), a status and the
// number of pairs summed. The block handles one item at a time: after an item is
// accepted, in_stall stays high while one shared multiplier adds the pair into the
// exact integer sums. A pair beyond MAX_PAIRS is dropped. A last pair then starts
// the closing sequence in one shift-add multiply-accumulate unit: three cross terms
// of a CNT_W+1 bit and an SX_W bit product, a variance check, the square of the
// numerator and the product of the two variances, both of NUM_W bits, and a root
// search for the coefficient magnitude, one result bit at a time.
// Status 2 (capacity exceeded) skips that sequence; status 1 (zero variance) skips the
// square, the variance product and the search.
// The result waits in the output register; while out_stall holds it, the block keeps
// it unchanged and holds any next result back until it has been handed over. A
// synchronous active-low reset clears all sums, the pair count and the overflow flag.
`default_nettype none

module pearson_correlation
  import pcc_pkg::*;
#(
  parameter int MAX_PAIRS   = 256,
  parameter int SAMPLE_BITS = 12
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  wire                               in_last_pair,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [COEF_W-1:0]          out_coefficient,
  output logic [STAT_W-1:0]                 out_status,
  output logic [$clog2(MAX_PAIRS + 1)-1:0]  out_pair_count
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
  localparam int NUM_W = 2 * SX_W;
  localparam int PRD_W = 2 * NUM_W;
  localparam int NB_W  = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_NUM_A, S_NUM_B, S_DX_A, S_DX_B, S_DY_A, S_DY_B,
    S_CHECK, S_SQ, S_DD, S_ROOT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  acc_ctl_t               acc_ctl;
  logic                   acc_done, acc_ovf;
  logic [CNT_W-1:0]       acc_cnt;
  logic signed [SX_W-1:0] sum_x, sum_y;
  logic signed [SQ_W-1:0] sum_xy, sum_xx, sum_yy;

  mac_ctl_t               mac_ctl_r, mac_ctl_nxt;
  logic [PRD_W-1:0]       mac_a;
  logic [NUM_W-1:0]       mac_b;
  logic [NB_W-1:0]        mac_nb;
  logic                   mac_done;
  logic [PRD_W-1:0]       mac_res;

  logic                   root_go_r, root_go_nxt;
  logic                   root_done;
  logic [ROOT_BITS-1:0]   root_q;

  logic                   last_r;
  logic [NUM_W-1:0]       num_r, dx_r, dy_r;
  logic [PRD_W-1:0]       t_r;
  logic signed [COEF_W-1:0] res_coef_r, res_coef_nxt;
  logic [STAT_W-1:0]      res_status_r, res_status_nxt;
  logic                   out_valid_r;
  logic signed [COEF_W-1:0] out_coef_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   load_out;
  logic                   var_bad;
  logic [COEF_W-1:0]      coef_mag;

  pcc_accum #(
    .MAX_PAIRS  (MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .SX_W       (SX_W),
    .SQ_W       (SQ_W)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .x     (in_sample_x),
    .y     (in_sample_y),
    .done  (acc_done),
    .ovf   (acc_ovf),
    .cnt   (acc_cnt),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .sum_xy(sum_xy),
    .sum_xx(sum_xx),
    .sum_yy(sum_yy)
  );

  pcc_mac #(
    .A_W(PRD_W),
    .B_W(NUM_W),
    .N_W(NB_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl_r),
    .a     (mac_a),
    .b     (mac_b),
    .nbits (mac_nb),
    .done  (mac_done),
    .result(mac_res)
  );

  pcc_root #(
    .T_W(PRD_W)
  ) u_root (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (root_go_r),
    .t    (t_r),
    .d    (mac_res),
    .done (root_done),
    .q    (root_q)
  );

  // Operands for the shared unit follow the current step. The unit samples
  // them in the cycle its go pulse is high, the first cycle of the step.
  always_comb begin
    mac_a  = '0;
    mac_b  = '0;
    mac_nb = '0;
    unique case (state_r)
      S_NUM_A: begin
        mac_a  = {{(PRD_W - SQ_W){sum_xy[SQ_W-1]}}, sum_xy};
        mac_b  = {{(NUM_W - CNT_W){1'b0}}, acc_cnt};
        mac_nb = NB_W'(CNT_W + 1);
      end
      S_DX_A: begin
        mac_a  = {{(PRD_W - SQ_W){sum_xx[SQ_W-1]}}, sum_xx};
        mac_b  = {{(NUM_W - CNT_W){1'b0}}, acc_cnt};
        mac_nb = NB_W'(CNT_W + 1);
      end
      S_DY_A: begin
        mac_a  = {{(PRD_W - SQ_W){sum_yy[SQ_W-1]}}, sum_yy};
        mac_b  = {{(NUM_W - CNT_W){1'b0}}, acc_cnt};
        mac_nb = NB_W'(CNT_W + 1);
      end
      S_NUM_B: begin
        mac_a  = {{(PRD_W - SX_W){sum_x[SX_W-1]}}, sum_x};
        mac_b  = {{(NUM_W - SX_W){sum_y[SX_W-1]}}, sum_y};
        mac_nb = NB_W'(SX_W);
      end
      S_DX_B: begin
        mac_a  = {{(PRD_W - SX_W){sum_x[SX_W-1]}}, sum_x};
        mac_b  = {{(NUM_W - SX_W){sum_x[SX_W-1]}}, sum_x};
        mac_nb = NB_W'(SX_W);
      end
      S_DY_B: begin
        mac_a  = {{(PRD_W - SX_W){sum_y[SX_W-1]}}, sum_y};
        mac_b  = {{(NUM_W - SX_W){sum_y[SX_W-1]}}, sum_y};
        mac_nb = NB_W'(SX_W);
      end
      S_SQ: begin
        mac_a  = {{(PRD_W - NUM_W){num_r[NUM_W-1]}}, num_r};
        mac_b  = num_r;
        mac_nb = NB_W'(NUM_W);
      end
      S_DD: begin
        mac_a  = {{(PRD_W - NUM_W){dx_r[NUM_W-1]}}, dx_r};
        mac_b  = dy_r;
        mac_nb = NB_W'(NUM_W);
      end
      default: begin
        mac_nb = '0;
      end
    endcase
  end

  // Both variances must be strictly positive; fewer than two pairs gives zero.
  assign var_bad  = dx_r[NUM_W-1] || (dx_r == '0) || dy_r[NUM_W-1] || (dy_r == '0);
  assign coef_mag = {1'b0, root_q};

  always_comb begin
    state_nxt      = state_r;
    acc_ctl        = '0;
    root_go_nxt    = 1'b0;
    load_out       = 1'b0;
    res_coef_nxt   = res_coef_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_ctl.start = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      S_ACC: begin
        if (acc_done) begin
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (acc_ovf) begin
            res_coef_nxt   = '0;
            res_status_nxt = STAT_OVERFLOW;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_NUM_A;
          end
        end
      end
      S_NUM_A: if (mac_done) state_nxt = S_NUM_B;
      S_NUM_B: if (mac_done) state_nxt = S_DX_A;
      S_DX_A:  if (mac_done) state_nxt = S_DX_B;
      S_DX_B:  if (mac_done) state_nxt = S_DY_A;
      S_DY_A:  if (mac_done) state_nxt = S_DY_B;
      S_DY_B:  if (mac_done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (var_bad) begin
          res_coef_nxt   = '0;
          res_status_nxt = STAT_ZERO_VAR;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: if (mac_done) state_nxt = S_DD;
      S_DD: begin
        if (mac_done) begin
          root_go_nxt = 1'b1;
          state_nxt   = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          res_coef_nxt   = num_r[NUM_W-1] ? (~coef_mag + COEF_W'(1)) : coef_mag;
          res_status_nxt = STAT_OK;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          acc_ctl.clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Each multiply step gets a go pulse as it is entered; the second half of
    // each difference accumulates onto the first with the product subtracted.
    mac_ctl_nxt.go = (state_nxt != state_r) &&
                     (state_nxt inside {S_NUM_A, S_NUM_B, S_DX_A, S_DX_B,
                                        S_DY_A, S_DY_B, S_SQ, S_DD});
    mac_ctl_nxt.accumulate = state_nxt inside {S_NUM_B, S_DX_B, S_DY_B};
    mac_ctl_nxt.subtract   = mac_ctl_nxt.accumulate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mac_ctl_r    <= '0;
      root_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mac_ctl_r <= mac_ctl_nxt;
      root_go_r <= root_go_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (acc_ctl.start) begin
      last_r <= in_last_pair;
    end
    if (mac_done) begin
      unique case (state_r)
        S_NUM_B: num_r <= mac_res[NUM_W-1:0];
        S_DX_B:  dx_r  <= mac_res[NUM_W-1:0];
        S_DY_B:  dy_r  <= mac_res[NUM_W-1:0];
        S_SQ:    t_r   <= mac_res;
        default: t_r   <= t_r;
      endcase
    end
    res_coef_r   <= res_coef_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_coef_r   <= res_coef_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= acc_cnt;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_status      = out_status_r;
  assign out_pair_count  = out_cnt_r;

endmodule

`default_nettype wire

[rtl/pcc_checker.sv]
// Port-level checks for the Pearson correlation block, bound to its top level.
// Depends on pcc_pkg and pearson_correlation.
`default_nettype none

module pcc_checker
  import pcc_pkg::*;
#(
  parameter int MAX_PAIRS = 256
) (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire logic signed [COEF_W-1:0]    out_coefficient,
  input wire logic [STAT_W-1:0]           out_status,
  input wire logic [$clog2(MAX_PAIRS + 1)-1:0] out_pair_count
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_ZERO_VAR ||
                   out_status == STAT_OVERFLOW))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_coefficient == '0)
    else $error("coefficient not zero on error status");

  a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |->
      out_pair_count >= CNT_W'(2) &&
      out_coefficient <= COEF_W'(COEF_ONE) && out_coefficient >= -COEF_W'(COEF_ONE))
    else $error("valid coefficient out of range or from too few pairs");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coefficient) &&
      $stable(out_status) && $stable(out_pair_count))
    else $error("stalled result changed");

endmodule

bind pearson_correlation pcc_checker #(
  .MAX_PAIRS(MAX_PAIRS)
) u_pcc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coefficient(out_coefficient),
  .out_status     (out_status),
  .out_pair_count (out_pair_count)
);

`default_nettype wire
